FILE: src/least_squares_line_fit_macros.svh
// Assertion macros shared by the line fit RTL.
// Depends on nothing; included by the top level.
`ifndef LEAST_SQUARES_LINE_FIT_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define LSLF_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must never hold outside reset.
`define LSLF_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

FILE: src/lslf_pkg.sv
// Shared types, constants and helper functions of the line fit block.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package lslf_pkg;

   localparam int SampleWidth = 16;
   localparam int MaxPoints   = 4096;
   localparam int CountWidth  = $clog2(MaxPoints + 1);
   localparam int SumWidth    = SampleWidth + CountWidth;
   localparam int SqWidth     = 2 * SampleWidth - 1;
   localparam int SumSqWidth  = SqWidth + CountWidth - 1;
   localparam int SumXyWidth  = SumSqWidth + 1;
   localparam int WordWidth   = 64;
   localparam int DivWidth    = 2 * WordWidth;
   localparam int FracBits    = 16;
   localparam int SlopeWidth  = 48;
   localparam int IcptWidth   = 64;
   localparam int R2Width     = FracBits + 1;
   localparam int R2One       = 1 << FracBits;
   localparam int QueueDepth  = 2;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TOO_FEW  = 2'd1,
      STATUS_X_EQUAL  = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_ISSUE,
      ST_MUL_WAIT,
      ST_CHECK,
      ST_DIV_ISSUE,
      ST_DIV_WAIT,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      logic [CountWidth-1:0]        count;
      logic signed [SumWidth-1:0]   sum_x;
      logic signed [SumWidth-1:0]   sum_y;
      logic signed [SumXyWidth-1:0] sum_xy;
      logic [SumSqWidth-1:0]        sum_xx;
      logic [SumSqWidth-1:0]        sum_yy;
      logic                         overflow;
   } snapshot_type;

   function automatic logic [WordWidth-1:0] mag_word(input logic [WordWidth-1:0] v);
      return v[WordWidth-1] ? (~v + WordWidth'(1)) : v;
   endfunction

   function automatic logic [SlopeWidth-1:0] sat_slope(input logic neg,
                                                       input logic [DivWidth-1:0] q);
      logic [DivWidth-1:0] lim;
      logic [DivWidth-1:0] v;
      lim = DivWidth'(1) << (SlopeWidth - 1);
      if (neg) begin
         v = (q > lim) ? lim : q;
         v = ~v + DivWidth'(1);
      end else begin
         v = (q > lim - DivWidth'(1)) ? lim - DivWidth'(1) : q;
      end
      return v[SlopeWidth-1:0];
   endfunction

   function automatic logic [IcptWidth-1:0] sat_icpt(input logic neg,
                                                     input logic [DivWidth-1:0] q);
      logic [DivWidth-1:0] lim;
      logic [DivWidth-1:0] v;
      lim = DivWidth'(1) << (IcptWidth - 1);
      if (neg) begin
         v = (q > lim) ? lim : q;
         v = ~v + DivWidth'(1);
      end else begin
         v = (q > lim - DivWidth'(1)) ? lim - DivWidth'(1) : q;
      end
      return v[IcptWidth-1:0];
   endfunction

   function automatic logic [R2Width-1:0] clamp_r2(input logic [DivWidth-1:0] q);
      return (q > DivWidth'(R2One)) ? R2Width'(R2One) : q[R2Width-1:0];
   endfunction

endpackage

FILE: src/lslf_front.sv
// Front part: accumulates point count and sums, snapshots them on the last point.
// Depends on lslf_pkg.
`timescale 1ns / 1ps
module lslf_front import lslf_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [SampleWidth-1:0] x_value,
   input  logic signed [SampleWidth-1:0] y_value,
   input  logic                          last_point,
   output logic                          snap_push,
   output snapshot_type                  snap
);

   snapshot_type acc_ff, acc_in, next_acc;
   logic signed [2*SampleWidth-1:0] xy, xx, yy;

   always_comb begin
      xy = x_value * y_value;
      xx = x_value * x_value;
      yy = y_value * y_value;
      next_acc = acc_ff;
      if (acc_ff.count < CountWidth'(MaxPoints)) begin
         next_acc.count  = acc_ff.count + CountWidth'(1);
         next_acc.sum_x  = acc_ff.sum_x + SumWidth'(x_value);
         next_acc.sum_y  = acc_ff.sum_y + SumWidth'(y_value);
         next_acc.sum_xy = acc_ff.sum_xy + SumXyWidth'(xy);
         next_acc.sum_xx = acc_ff.sum_xx + SumSqWidth'(xx[SqWidth-1:0]);
         next_acc.sum_yy = acc_ff.sum_yy + SumSqWidth'(yy[SqWidth-1:0]);
      end else begin
         next_acc.overflow = 1'b1;
      end
      acc_in = acc_ff;
      if (accept) begin
         acc_in = last_point ? '0 : next_acc;
      end
   end

   assign snap      = next_acc;
   assign snap_push = accept & last_point;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

FILE: src/lslf_queue.sv
// Short queue of accumulated sets between the front and back parts.
// Depends on lslf_pkg.
`timescale 1ns / 1ps
module lslf_queue import lslf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  snapshot_type push_data,
   input  logic         pop,
   output snapshot_type head,
   output logic         full,
   output logic         empty
);

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int CntWidth = $clog2(QueueDepth + 1);

   snapshot_type entry_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full    = cnt_ff == CntWidth'(QueueDepth);
   assign empty   = cnt_ff == '0;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrWidth'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrWidth'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: src/lslf_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on lslf_pkg.
`timescale 1ns / 1ps
module lslf_mul import lslf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WordWidth-1:0] a,
   input  logic [WordWidth-1:0] b,
   output logic                 done,
   output logic [DivWidth-1:0]  prod_mag,
   output logic                 prod_neg
);

   localparam int CntWidth = $clog2(WordWidth + 1);

   logic [DivWidth-1:0]  mc_ff, acc_ff;
   logic [WordWidth-1:0] mp_ff;
   logic [CntWidth-1:0]  cnt_ff;
   logic                 busy_ff, done_ff, neg_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         mc_ff  <= DivWidth'(mag_word(a));
         mp_ff  <= mag_word(b);
         acc_ff <= '0;
         neg_ff <= a[WordWidth-1] ^ b[WordWidth-1];
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_ff <= acc_ff + mc_ff;
         end
         mc_ff <= mc_ff << 1;
         mp_ff <= mp_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntWidth'(WordWidth);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CntWidth'(1);
            if (cnt_ff == CntWidth'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign prod_mag = acc_ff;
   assign prod_neg = neg_ff;

endmodule

FILE: src/lslf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lslf_pkg.
`timescale 1ns / 1ps
module lslf_div import lslf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DivWidth-1:0] num,
   input  logic [DivWidth-1:0] den,
   output logic                done,
   output logic [DivWidth-1:0] quo
);

   localparam int CntWidth = $clog2(DivWidth + 1);

   logic [DivWidth:0]   rem_ff, rem_sh;
   logic [DivWidth-1:0] quo_ff, den_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic                busy_ff, done_ff, ge;

   assign rem_sh = {rem_ff[DivWidth-1:0], quo_ff[DivWidth-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_ff <= {quo_ff[DivWidth-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntWidth'(DivWidth);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CntWidth'(1);
            if (cnt_ff == CntWidth'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

FILE: src/lslf_back.sv
// Back part: forms the centered sums, divides, saturates and holds the result.
// Depends on lslf_pkg, lslf_mul and lslf_div.
`timescale 1ns / 1ps
module lslf_back import lslf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  snapshot_type           job,
   output logic                   job_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [SlopeWidth-1:0]  rsp_slope_q16,
   output logic [IcptWidth-1:0]   rsp_intercept_q16,
   output logic [R2Width-1:0]     rsp_r_squared_q16,
   output logic [1:0]             rsp_fit_status,
   output logic [CountWidth-1:0]  rsp_point_count
);

   localparam logic [3:0] MUL_NXX = 4'd0;
   localparam logic [3:0] MUL_XX  = 4'd1;
   localparam logic [3:0] MUL_NYY = 4'd2;
   localparam logic [3:0] MUL_YY  = 4'd3;
   localparam logic [3:0] MUL_NXY = 4'd4;
   localparam logic [3:0] MUL_XY  = 4'd5;
   localparam logic [3:0] MUL_YXX = 4'd6;
   localparam logic [3:0] MUL_XXY = 4'd7;
   localparam logic [3:0] MUL_DEN = 4'd8;
   localparam logic [3:0] MUL_SQ  = 4'd9;
   localparam logic [3:0] DIV_SLOPE = 4'd0;
   localparam logic [3:0] DIV_ICPT  = 4'd1;
   localparam logic [3:0] DIV_R2    = 4'd2;

   back_state_type state_ff, state_in;
   snapshot_type   job_ff;
   logic [3:0]     step_ff;
   logic [DivWidth-1:0]  tmp_ff, num_ff, den_ff, sq_ff;
   logic [WordWidth-1:0] sxx_ff, syy_ff, sxy_ff;
   logic [SlopeWidth-1:0] slope_ff;
   logic [IcptWidth-1:0]  icpt_ff;
   logic [R2Width-1:0]    r2_ff;
   status_type            status_ff;

   logic mul_start, mul_done, mul_neg, div_start, div_done;
   logic [WordWidth-1:0] mul_a, mul_b, n_w, sx_w, sy_w, sxy_w, sxx_w, syy_w;
   logic [DivWidth-1:0]  mul_mag, sprod, div_num, div_den, div_quo, num_mag;

   assign n_w   = WordWidth'(job_ff.count);
   assign sx_w  = WordWidth'($signed(job_ff.sum_x));
   assign sy_w  = WordWidth'($signed(job_ff.sum_y));
   assign sxy_w = WordWidth'($signed(job_ff.sum_xy));
   assign sxx_w = WordWidth'(job_ff.sum_xx);
   assign syy_w = WordWidth'(job_ff.sum_yy);
   assign sprod = mul_neg ? (~mul_mag + DivWidth'(1)) : mul_mag;
   assign num_mag = num_ff[DivWidth-1] ? (~num_ff + DivWidth'(1)) : num_ff;

   always_comb begin
      case (step_ff)
         MUL_NXX: begin mul_a = n_w;    mul_b = sxx_w;  end
         MUL_XX:  begin mul_a = sx_w;   mul_b = sx_w;   end
         MUL_NYY: begin mul_a = n_w;    mul_b = syy_w;  end
         MUL_YY:  begin mul_a = sy_w;   mul_b = sy_w;   end
         MUL_NXY: begin mul_a = n_w;    mul_b = sxy_w;  end
         MUL_XY:  begin mul_a = sx_w;   mul_b = sy_w;   end
         MUL_YXX: begin mul_a = sy_w;   mul_b = sxx_w;  end
         MUL_XXY: begin mul_a = sx_w;   mul_b = sxy_w;  end
         MUL_DEN: begin mul_a = sxx_ff; mul_b = syy_ff; end
         MUL_SQ:  begin mul_a = sxy_ff; mul_b = sxy_ff; end
         default: begin mul_a = '0;     mul_b = '0;     end
      endcase
   end

   always_comb begin
      case (step_ff)
         DIV_SLOPE: begin
            div_num = DivWidth'({mag_word(sxy_ff), FracBits'(0)});
            div_den = DivWidth'(mag_word(sxx_ff));
         end
         DIV_ICPT: begin
            div_num = {num_mag[DivWidth-FracBits-1:0], FracBits'(0)};
            div_den = DivWidth'(mag_word(sxx_ff));
         end
         default: begin
            div_num = {sq_ff[DivWidth-FracBits-1:0], FracBits'(0)};
            div_den = den_ff;
         end
      endcase
   end

   lslf_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_start),
      .a        (mul_a),
      .b        (mul_b),
      .done     (mul_done),
      .prod_mag (mul_mag),
      .prod_neg (mul_neg)
   );

   lslf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) state_in = ST_MUL_ISSUE;
         end
         ST_MUL_ISSUE: state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (mul_done) state_in = (step_ff == MUL_SQ) ? ST_CHECK : ST_MUL_ISSUE;
         end
         ST_CHECK: begin
            if (job_ff.count < CountWidth'(2) || sxx_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV_ISSUE;
            end
         end
         ST_DIV_ISSUE: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (step_ff == DIV_R2 || (step_ff == DIV_ICPT && syy_ff == '0)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV_ISSUE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_pop) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      job_pop   = (state_ff == ST_IDLE) & job_valid;
      mul_start = state_ff == ST_MUL_ISSUE;
      div_start = state_ff == ST_DIV_ISSUE;
      rsp_empty = state_ff != ST_DONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (job_pop) begin
            step_ff <= '0;
         end else if (state_ff == ST_MUL_WAIT && mul_done) begin
            step_ff <= (step_ff == MUL_SQ) ? DIV_SLOPE : step_ff + 4'd1;
         end else if (state_ff == ST_DIV_WAIT && div_done) begin
            step_ff <= step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff   <= job;
         slope_ff <= '0;
         icpt_ff  <= '0;
         r2_ff    <= '0;
      end
      if (state_ff == ST_MUL_WAIT && mul_done) begin
         case (step_ff)
            MUL_XX:  sxx_ff <= tmp_ff[WordWidth-1:0] - sprod[WordWidth-1:0];
            MUL_YY:  syy_ff <= tmp_ff[WordWidth-1:0] - sprod[WordWidth-1:0];
            MUL_XY:  sxy_ff <= tmp_ff[WordWidth-1:0] - sprod[WordWidth-1:0];
            MUL_XXY: num_ff <= tmp_ff - sprod;
            MUL_DEN: den_ff <= mul_mag;
            MUL_SQ:  sq_ff  <= mul_mag;
            default: tmp_ff <= sprod;
         endcase
      end
      if (state_ff == ST_CHECK) begin
         if (job_ff.count < CountWidth'(2)) begin
            status_ff <= STATUS_TOO_FEW;
         end else if (sxx_ff == '0) begin
            status_ff <= STATUS_X_EQUAL;
         end else begin
            status_ff <= job_ff.overflow ? STATUS_OVERFLOW : STATUS_OK;
         end
      end
      if (state_ff == ST_DIV_WAIT && div_done) begin
         case (step_ff)
            DIV_SLOPE: slope_ff <= sat_slope(sxy_ff[WordWidth-1] ^ sxx_ff[WordWidth-1],
                                             div_quo);
            DIV_ICPT:  icpt_ff  <= sat_icpt(num_ff[DivWidth-1] ^ sxx_ff[WordWidth-1],
                                            div_quo);
            default:   r2_ff    <= clamp_r2(div_quo);
         endcase
      end
   end

   assign rsp_slope_q16     = slope_ff;
   assign rsp_intercept_q16 = icpt_ff;
   assign rsp_r_squared_q16 = r2_ff;
   assign rsp_fit_status    = status_ff;
   assign rsp_point_count   = job_ff.count;

endmodule

FILE: src/least_squares_line_fit.sv
// Top level of the least-squares line fit block.
// Depends on lslf_pkg, lslf_front, lslf_queue, lslf_back and the macros header.
`timescale 1ns / 1ps
`include "least_squares_line_fit_macros.svh"

// Points are taken one per cycle while the queue is not full and folded into
// running sums. The point marked last closes the set and hands its sums through
// a two-entry queue to the fit engine, which works them out with one bit-serial
// 64-bit multiplier (ten products) and one bit-serial 128-bit divider (up to
// three quotients). Point input stalls only when two finished sets already
// wait in the queue; a result stays on the rsp_ ports until it is popped.
module least_squares_line_fit import lslf_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [SampleWidth-1:0] req_x_value,
   input  logic signed [SampleWidth-1:0] req_y_value,
   input  logic                          req_last_point,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [SlopeWidth-1:0]  rsp_slope_q16,
   output logic signed [IcptWidth-1:0]   rsp_intercept_q16,
   output logic [R2Width-1:0]            rsp_r_squared_q16,
   output logic [1:0]                    rsp_fit_status,
   output logic [CountWidth-1:0]         rsp_point_count
);

   logic         accept, snap_push, q_empty, job_pop;
   snapshot_type snap, head;

   assign accept = req_push & ~req_full;

   lslf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .x_value    (req_x_value),
      .y_value    (req_y_value),
      .last_point (req_last_point),
      .snap_push  (snap_push),
      .snap       (snap)
   );

   lslf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (snap_push),
      .push_data (snap),
      .pop       (job_pop),
      .head      (head),
      .full      (req_full),
      .empty     (q_empty)
   );

   lslf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (~q_empty),
      .job               (head),
      .job_pop           (job_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_slope_q16     (rsp_slope_q16),
      .rsp_intercept_q16 (rsp_intercept_q16),
      .rsp_r_squared_q16 (rsp_r_squared_q16),
      .rsp_fit_status    (rsp_fit_status),
      .rsp_point_count   (rsp_point_count)
   );

   `LSLF_ASSERT_NEVER(a_r2_range, clock, reset, !rsp_empty && rsp_r_squared_q16 > R2Width'(R2One), "r-squared above one")
   `LSLF_ASSERT_IMPLY(a_too_few_zero, clock, reset, !rsp_empty && rsp_fit_status == STATUS_TOO_FEW, rsp_slope_q16 == '0 && rsp_intercept_q16 == '0 && rsp_point_count < CountWidth'(2), "too-few result not cleared")
   `LSLF_ASSERT_IMPLY(a_ok_count, clock, reset, !rsp_empty && (rsp_fit_status == STATUS_OK || rsp_fit_status == STATUS_X_EQUAL), rsp_point_count >= CountWidth'(2), "fit from fewer than two points")
   `LSLF_ASSERT_IMPLY(a_pop_clears, clock, reset, !rsp_empty && rsp_pop, ##1 rsp_empty, "result seen twice")

endmodule
